>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: action and status codes,
// widths and the request record passed from the front end to the back end.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned MAG_W = 64;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Request kinds after classification in the front end.
  localparam logic [1:0] K_FIXED = 2'd0; // result known up front
  localparam logic [1:0] K_ADD = 2'd1;   // n = x +/- y, d = p
  localparam logic [1:0] K_MUL = 2'd2;   // n = x, d = p (products only)
  localparam logic [1:0] K_CMP = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sub;
    logic [1:0]  fixed_status;
    logic        s0;         // sign of first factor pair for n
    logic [31:0] m0a, m0b;   // first numerator product factors
    logic        s1;
    logic [31:0] m1a, m1b;   // second numerator product factors
    logic        sd;
    logic [31:0] mda, mdb;   // denominator product factors
  } req_t;

  localparam int unsigned REQ_W = $bits(req_t);

endpackage

>>> sv/rational_arithmetic_unit_core.sv
// Rational arithmetic unit. Each request (action and two fractions) gives
// one reduced result; a request passes through the products, a binary gcd
// (one shift or subtract per cycle) and two bit-serial divisions by the
// gcd on the shared divider, then the hand-off to the output register.
// Early-out cases (zero denominator, divide by zero, compare, zero
// numerator) skip the gcd and the divisions. A two-entry queue holds
// requests while the back end is busy.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_order,
  output logic [1:0]         out_status
);
  logic          f_valid, f_stall, b_valid, b_stall;
  rau_pkg::req_t f_req, b_req;

  rau_front u_front (
    .in_valid, .in_stall, .in_action, .in_a_num, .in_a_den, .in_b_num,
    .in_b_den, .q_valid(f_valid), .q_stall(f_stall), .q_req(f_req)
  );

  rau_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_req),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_req)
  );

  rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_stall(b_stall), .q_req(b_req),
    .out_valid, .out_stall, .out_res_num, .out_res_den, .out_order, .out_status
  );
endmodule

>>> sv/rau_fifo.sv
// Two-entry request queue between front end and back end.
// Depends on rau_pkg for the request width.
`timescale 1ns / 1ps
module rau_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_stall,
  input  logic [rau_pkg::REQ_W-1:0] wr_data,
  output logic                     rd_valid,
  input  logic                     rd_stall,
  output logic [rau_pkg::REQ_W-1:0] rd_data
);
  logic [rau_pkg::REQ_W-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && !wr_stall;
  assign rd_en    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

>>> sv/rau_front.sv
// Front end: takes the request, checks denominators, divisor and action, and
// lines up the sign/magnitude factors for the back end. Uses rau_pkg.
`timescale 1ns / 1ps
module rau_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rau_pkg::ACT_W-1:0]   in_action,
  input  logic signed [31:0]         in_a_num,
  input  logic signed [31:0]         in_a_den,
  input  logic signed [31:0]         in_b_num,
  input  logic signed [31:0]         in_b_den,
  output logic                       q_valid,
  input  logic                       q_stall,
  output rau_pkg::req_t              q_req
);
  logic        an_s, ad_s, bn_s, bd_s;
  logic [31:0] an_m, ad_m, bn_m, bd_m;

  assign in_stall = q_stall;
  assign q_valid  = in_valid;

  assign an_s = in_a_num[31];
  assign ad_s = in_a_den[31];
  assign bn_s = in_b_num[31];
  assign bd_s = in_b_den[31];
  assign an_m = an_s ? (32'd0 - in_a_num) : in_a_num;
  assign ad_m = ad_s ? (32'd0 - in_a_den) : in_a_den;
  assign bn_m = bn_s ? (32'd0 - in_b_num) : in_b_num;
  assign bd_m = bd_s ? (32'd0 - in_b_den) : in_b_den;

  always_comb begin
    q_req = '0;
    q_req.s0 = an_s ^ bd_s;
    q_req.m0a = an_m;
    q_req.m0b = bd_m;
    q_req.s1 = bn_s ^ ad_s;
    q_req.m1a = bn_m;
    q_req.m1b = ad_m;
    q_req.sd = ad_s ^ bd_s;
    q_req.mda = ad_m;
    q_req.mdb = bd_m;
    if (ad_m == 32'd0 || bd_m == 32'd0) begin
      q_req.kind = rau_pkg::K_FIXED;
      q_req.fixed_status = rau_pkg::ST_ZDEN;
    end else begin
      case (in_action)
        rau_pkg::ACT_ADD: q_req.kind = rau_pkg::K_ADD;
        rau_pkg::ACT_SUB: begin
          q_req.kind = rau_pkg::K_ADD;
          q_req.sub = 1'b1;
        end
        rau_pkg::ACT_CMP: begin
          q_req.kind = rau_pkg::K_CMP;
          q_req.sub = 1'b1;
        end
        rau_pkg::ACT_MUL: begin
          q_req.kind = rau_pkg::K_MUL;
          q_req.s0 = an_s ^ bn_s;
          q_req.m0b = bn_m;
        end
        rau_pkg::ACT_DIV: begin
          if (bn_m == 32'd0) begin
            q_req.kind = rau_pkg::K_FIXED;
            q_req.fixed_status = rau_pkg::ST_DIVZ;
          end else begin
            q_req.kind = rau_pkg::K_MUL;
            q_req.sd = ad_s ^ bn_s;
            q_req.mdb = bn_m;
          end
        end
        default: begin
          q_req.kind = rau_pkg::K_FIXED;
          q_req.fixed_status = rau_pkg::ST_OK;
        end
      endcase
    end
  end
endmodule

>>> sv/rau_back.sv
// Back end: products, sum, binary gcd, then two restoring divisions by
// the gcd, with an output register. Uses rau_pkg.
`timescale 1ns / 1ps
module rau_back #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_stall,
  input  rau_pkg::req_t       q_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic [1:0]          out_order,
  output logic [1:0]          out_status
);
  localparam int unsigned MW = rau_pkg::MAG_W;
  localparam logic [MW-1:0] LIM = (MW'(1) << (OPERAND_WIDTH - 1)) - MW'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MUL0 = 8'b00000010,
    S_MUL1 = 8'b00000100,
    S_SUM  = 8'b00001000,
    S_GCD  = 8'b00010000,
    S_DIVN = 8'b00100000,
    S_DIVD = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t        state_r;
  rau_pkg::req_t req_r;
  logic [MW-1:0] p0_r, p1_r, nm_r, dm_r;
  logic          p0s_r, p1s_r, ns_r;
  logic [MW-1:0] gu_r, gv_r;
  logic [6:0]    gk_r;
  logic [MW-1:0] g_r, quo_r, rem_r, dq_r;
  logic [6:0]    cnt_r;
  logic [31:0]   res_num_r;
  logic [30:0]   res_den_r;
  logic [1:0]    res_ord_r, res_st_r;
  logic [MW-1:0] mul_res;
  logic [MW-1:0] gdiff, rem_sh;
  logic          rem_ge;
  logic          out_load;

  // One 32x32 multiplier, used in turn for the three products.
  always_comb begin
    case (state_r)
      S_IDLE:  mul_res = 64'(q_req.m0a) * 64'(q_req.m0b);
      S_MUL0:  mul_res = 64'(req_r.m1a) * 64'(req_r.m1b);
      default: mul_res = 64'(req_r.mda) * 64'(req_r.mdb);
    endcase
  end

  assign q_stall  = (state_r != S_IDLE);
  assign gdiff    = (gu_r > gv_r) ? gu_r - gv_r : gv_r - gu_r;
  assign rem_sh   = {rem_r[MW-2:0], quo_r[MW-1]};
  assign rem_ge   = (rem_sh >= g_r);
  assign out_load = (state_r == S_DONE) && (!out_valid || !out_stall);

  // Output register: a finished result moves out only once the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_res_num <= res_num_r;
      out_res_den <= res_den_r;
      out_order <= res_ord_r;
      out_status <= res_st_r;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          req_r <= q_req;
          p0_r <= mul_res;
          p0s_r <= q_req.s0;
          if (q_req.kind == rau_pkg::K_FIXED) begin
            res_num_r <= '0;
            res_den_r <= 31'd1;
            res_ord_r <= rau_pkg::ORD_LT;
            res_st_r <= q_req.fixed_status;
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          p1_r <= mul_res;
          p1s_r <= req_r.s1 ^ req_r.sub;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          dm_r <= mul_res;
          if (req_r.kind == rau_pkg::K_MUL) begin
            nm_r <= p0_r;
            ns_r <= p0s_r;
          end else if ((p0s_r == p1s_r) || p0_r == 64'd0 || p1_r == 64'd0) begin
            nm_r <= p0_r + p1_r;
            ns_r <= (p0_r != 64'd0) ? p0s_r : p1s_r;
          end else if (p0_r >= p1_r) begin
            nm_r <= p0_r - p1_r;
            ns_r <= p0s_r;
          end else begin
            nm_r <= p1_r - p0_r;
            ns_r <= p1s_r;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_den_r <= 31'd1;
          res_num_r <= '0;
          res_st_r <= rau_pkg::ST_OK;
          if (req_r.kind == rau_pkg::K_CMP) begin
            if (nm_r == 64'd0) res_ord_r <= rau_pkg::ORD_EQ;
            else if (ns_r != req_r.sd) res_ord_r <= rau_pkg::ORD_LT;
            else res_ord_r <= rau_pkg::ORD_GT;
            state_r <= S_DONE;
          end else begin
            res_ord_r <= rau_pkg::ORD_LT;
            if (nm_r == 64'd0) begin
              state_r <= S_DONE;
            end else begin
              gu_r <= nm_r;
              gv_r <= dm_r;
              gk_r <= '0;
              state_r <= S_GCD;
            end
          end
        end
        // Binary gcd: one shift or one subtract per cycle.
        S_GCD: begin
          if (gu_r == gv_r) begin
            g_r <= gu_r << gk_r;
            quo_r <= nm_r;
            rem_r <= '0;
            cnt_r <= '0;
            state_r <= S_DIVN;
          end else if (!gu_r[0] && !gv_r[0]) begin
            gu_r <= gu_r >> 1;
            gv_r <= gv_r >> 1;
            gk_r <= gk_r + 7'd1;
          end else if (!gu_r[0]) begin
            gu_r <= gu_r >> 1;
          end else if (!gv_r[0]) begin
            gv_r <= gv_r >> 1;
          end else if (gu_r > gv_r) begin
            gu_r <= gdiff >> 1;
          end else begin
            gv_r <= gdiff >> 1;
          end
        end
        // Restoring division, one quotient bit per cycle, numerator then
        // denominator.
        S_DIVN, S_DIVD: begin
          if (cnt_r == 7'(MW - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (state_r == S_DIVN) begin
              dq_r <= {quo_r[MW-2:0], rem_ge};
              quo_r <= dm_r;
              state_r <= S_DIVD;
            end else begin
              if (dq_r > LIM || {quo_r[MW-2:0], rem_ge} > LIM) begin
                res_st_r <= rau_pkg::ST_OVF;
              end else begin
                res_num_r <= (ns_r != req_r.sd) ? 32'd0 - dq_r[31:0] : dq_r[31:0];
                res_den_r <= {quo_r[29:0], rem_ge};
              end
              state_r <= S_DONE;
            end
          end else begin
            cnt_r <= cnt_r + 7'd1;
            rem_r <= rem_ge ? rem_sh - g_r : rem_sh;
            quo_r <= {quo_r[MW-2:0], rem_ge};
          end
        end
        S_DONE: if (out_load) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
